// File: src/closest_point_on_segment_macros.svh
// ----------------------------------------------------------------------------
// closest point on segment assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define CPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cps assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cps assertion failed");

`else

`define CPS_ASSERT_IMP(lbl, ante, cons)
`define CPS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: src/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// types, widths and helpers shared by the closest point on segment block
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int COORD_W        = 32;   // q16.16 coordinate
    localparam int MAG_W          = 33;   // magnitude of a coordinate difference
    localparam int PROD_W         = 2 * MAG_W;
    localparam int WIDE_W         = PROD_W + 2;  // sum of three products
    localparam int FRAC_W         = 31;   // projection fraction, 0.31
    localparam int NRM_W          = 16;   // q2.14 normal
    localparam int NRM_ONE        = 16384;
    localparam int B_W            = 22;   // normalized magnitude
    localparam int SH_W           = 4;
    localparam int SQ_W           = 2 * B_W;
    localparam int M2_W           = SQ_W + 2;
    localparam int ISQ_W          = 64;
    localparam int SQ_STEPS       = 32;
    localparam int R_W            = 32;
    localparam int NUM_W          = 47;
    localparam int QUO_W          = 15;
    localparam int CFG_IDX_W      = 3;
    localparam int DIMS_DEF       = 3;
    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_START_Z,
        CFG_END_X,
        CFG_END_Y,
        CFG_END_Z
    } cps_cfg_idx_t;

    typedef enum logic [1:0] {
        REG_START,
        REG_END,
        REG_EDGE
    } cps_region_t;

    typedef logic [2:0][COORD_W-1:0] cps_vec_t;

    typedef struct packed {
        cps_vec_t s;
        cps_vec_t e;
    } cps_seg_t;

    // word handed from the front end to the back end
    typedef struct packed {
        cps_vec_t          q;
        logic              wp;
        logic              wn;
        cps_region_t       region;
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] dd;
    } cps_item_t;

    // closest point word between projection and normal units
    typedef struct packed {
        cps_vec_t q;
        cps_vec_t c;
        logic     wp;
        logic     wn;
        logic     on_edge;
    } cps_pt_t;

    function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    // end minus start on one axis, sign extended
    function automatic logic [MAG_W-1:0] seg_delta(input cps_seg_t seg,
                                                   input logic [1:0] i);
        return {seg.e[i][COORD_W-1], seg.e[i]} - {seg.s[i][COORD_W-1], seg.s[i]};
    endfunction

endpackage

// File: src/closest_point_on_segment.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment
// closest point on a configured segment, unit normal and contact type
// ----------------------------------------------------------------------------
// usage:
//   load the segment endpoints through cfg_we / cfg_idx / cfg_wdata while no
//   query is in flight; indexes 0..2 are the start x/y/z, 3..5 the end x/y/z
//   (q16.16). each query word on in_valid/in_ready carries a q16.16 point and
//   the want_point / want_normal requests; each result word on
//   out_valid/out_ready carries the point, a q2.14 normal and contact_type.
//   throughput is one word per cycle with no stalls. a word passes 4 front
//   stages, the queue, the projection divide stages, 2 registers for the
//   point, 4 for range reduction, 32 square root stages, the normal divide
//   stages and the result reg, the first of them loaded at the accepting edge.
//   reset clears the endpoints to zero and drops every word in flight.
//   when out_ready is low with a word on the output the back pipeline holds;
//   the front keeps taking words until its queue (FIFO_DEPTH entries, 4 by
//   default) is full and its last stage holds a word, then in_ready drops.
// ----------------------------------------------------------------------------
module closest_point_on_segment #(
    parameter int DIMS       = cps_pkg::DIMS_DEF,
    parameter int FIFO_DEPTH = cps_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [cps_pkg::COORD_W-1:0]       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                query_x,
    input  logic signed [31:0]                query_y,
    input  logic signed [31:0]                query_z,
    input  logic                              want_point,
    input  logic                              want_normal,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                point_x,
    output logic signed [31:0]                point_y,
    output logic signed [31:0]                point_z,
    output logic signed [15:0]                normal_x,
    output logic signed [15:0]                normal_y,
    output logic signed [15:0]                normal_z,
    output logic                              contact_type
);

    cps_pkg::cps_seg_t  seg_reg;
    cps_pkg::cps_item_t fr_item, q_item;
    logic               fr_valid, fr_ready, q_valid, q_ready;
    logic               adv;
    logic               pt_valid;
    cps_pkg::cps_pt_t   pt;
    cps_pkg::cps_vec_t  res_point;
    logic [2:0][cps_pkg::NRM_W-1:0] res_normal;
    logic               res_edge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cps_pkg::cps_cfg_idx_t'(cfg_idx))
                cps_pkg::CFG_START_X: seg_reg.s[0] <= cfg_wdata;
                cps_pkg::CFG_START_Y: seg_reg.s[1] <= cfg_wdata;
                cps_pkg::CFG_START_Z: seg_reg.s[2] <= cfg_wdata;
                cps_pkg::CFG_END_X:   seg_reg.e[0] <= cfg_wdata;
                cps_pkg::CFG_END_Y:   seg_reg.e[1] <= cfg_wdata;
                cps_pkg::CFG_END_Z:   seg_reg.e[2] <= cfg_wdata;
                default:              seg_reg <= seg_reg;
            endcase
        end
    end

    cps_front #(
        .DIMS (DIMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg         (seg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .query_x     (query_x),
        .query_y     (query_y),
        .query_z     (query_z),
        .want_point  (want_point),
        .want_normal (want_normal),
        .item_valid  (fr_valid),
        .item_ready  (fr_ready),
        .item        (fr_item)
    );

    cps_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

    cps_proj #(
        .DIMS (DIMS)
    ) u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg        (seg_reg),
        .adv        (adv),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .pt_valid   (pt_valid),
        .pt         (pt)
    );

    cps_norm #(
        .DIMS (DIMS)
    ) u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt         (pt),
        .out_ready  (out_ready),
        .adv        (adv),
        .out_valid  (out_valid),
        .out_point  (res_point),
        .out_normal (res_normal),
        .out_edge   (res_edge)
    );

    assign point_x      = res_point[0];
    assign point_y      = res_point[1];
    assign point_z      = res_point[2];
    assign normal_x     = res_normal[0];
    assign normal_y     = res_normal[1];
    assign normal_z     = res_normal[2];
    assign contact_type = res_edge;

endmodule

// File: src/cps_front.sv
// ----------------------------------------------------------------------------
// cps_front
// accepts query words, forms the exact dot products and sorts into regions
// ----------------------------------------------------------------------------
module cps_front #(
    parameter int DIMS = cps_pkg::DIMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cps_pkg::cps_seg_t   seg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  query_x,
    input  logic signed [31:0]  query_y,
    input  logic signed [31:0]  query_z,
    input  logic                want_point,
    input  logic                want_normal,
    output logic                item_valid,
    input  logic                item_ready,
    output cps_pkg::cps_item_t  item
);

    localparam int MW = cps_pkg::MAG_W;
    localparam int PW = cps_pkg::PROD_W;
    localparam int WW = cps_pkg::WIDE_W;
    localparam int CW = cps_pkg::COORD_W;

    typedef struct packed {
        cps_pkg::cps_vec_t q;
        logic              wp;
        logic              wn;
    } front_tag_t;

    logic adv;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    front_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    front_tag_t s1_tag_next;

    logic [2:0][MW-1:0] ad_reg, av_reg, ad_next, av_next;
    logic [2:0]         neg_reg, neg_next, neg2_reg;
    logic [2:0][PW-1:0] pdd_reg, pdv_reg, pdd_next, pdv_next;
    logic [WW-1:0]      tp_reg, tn_reg, dd_reg, tp_next, tn_next, dd_next;
    cps_pkg::cps_item_t item_reg, item_next;

    assign adv        = !s4_valid_reg || item_ready;
    assign in_ready   = adv;
    assign item_valid = s4_valid_reg;
    assign item       = item_reg;

    // stage 1: differences from the start point
    always_comb
    begin
        logic [MW-1:0] d;
        logic [MW-1:0] v;
        s1_tag_next.q  = {query_z, query_y, query_x};
        s1_tag_next.wp = want_point;
        s1_tag_next.wn = want_normal;
        for (int i = 0; i < 3; i++)
        begin
            d = cps_pkg::seg_delta(seg, 2'(i));
            v = {s1_tag_next.q[i][CW-1], s1_tag_next.q[i]}
                - {seg.s[i][CW-1], seg.s[i]};
            if (i < DIMS)
            begin
                ad_next[i]  = cps_pkg::mag(d);
                av_next[i]  = cps_pkg::mag(v);
                neg_next[i] = d[MW-1] ^ v[MW-1];
            end
            else
            begin
                ad_next[i]  = '0;
                av_next[i]  = '0;
                neg_next[i] = 1'b0;
            end
        end
    end

    // stage 2: products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pdd_next[i] = ad_reg[i] * ad_reg[i];
            pdv_next[i] = ad_reg[i] * av_reg[i];
        end
    end

    // stage 3: dot products, split by sign
    always_comb
    begin
        tp_next = '0;
        tn_next = '0;
        dd_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dd_next = dd_next + WW'(pdd_reg[i]);
            if (neg2_reg[i])
                tn_next = tn_next + WW'(pdv_reg[i]);
            else
                tp_next = tp_next + WW'(pdv_reg[i]);
        end
    end

    // stage 4: region
    always_comb
    begin
        logic [WW:0] lim;
        lim            = {1'b0, tn_reg} + {1'b0, dd_reg};
        item_next.q    = s3_tag_reg.q;
        item_next.wp   = s3_tag_reg.wp;
        item_next.wn   = s3_tag_reg.wn;
        item_next.rem  = tp_reg - tn_reg;
        item_next.dd   = dd_reg;
        if (tp_reg <= tn_reg)
            item_next.region = cps_pkg::REG_START;
        else if ({1'b0, tp_reg} >= lim)
            item_next.region = cps_pkg::REG_END;
        else
            item_next.region = cps_pkg::REG_EDGE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= s1_tag_next;
            ad_reg     <= ad_next;
            av_reg     <= av_next;
            neg_reg    <= neg_next;
            s2_tag_reg <= s1_tag_reg;
            pdd_reg    <= pdd_next;
            pdv_reg    <= pdv_next;
            neg2_reg   <= neg_reg;
            s3_tag_reg <= s2_tag_reg;
            tp_reg     <= tp_next;
            tn_reg     <= tn_next;
            dd_reg     <= dd_next;
            item_reg   <= item_next;
        end
    end

endmodule

// File: src/cps_fifo.sv
// ----------------------------------------------------------------------------
// cps_fifo
// short queue of classified words between the front and back ends
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_macros.svh"

module cps_fifo #(
    parameter int DEPTH = cps_pkg::FIFO_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  cps_pkg::cps_item_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output cps_pkg::cps_item_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cps_pkg::cps_item_t mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push, pop;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `CPS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `CPS_ASSERT_NXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `CPS_ASSERT_NXT(a_cnt_down, pop && !push, cnt_reg == $past(cnt_reg) - CNT_W'(1))

endmodule

// File: src/cps_proj.sv
// ----------------------------------------------------------------------------
// cps_proj
// projection fraction by restoring division, one bit per stage, then the
// closest point on the segment
// ----------------------------------------------------------------------------
module cps_proj #(
    parameter int DIMS = cps_pkg::DIMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cps_pkg::cps_seg_t  seg,
    input  logic               adv,
    input  logic               item_valid,
    output logic               item_ready,
    input  cps_pkg::cps_item_t item,
    output logic               pt_valid,
    output cps_pkg::cps_pt_t   pt
);

    localparam int FW  = cps_pkg::FRAC_W;
    localparam int WW  = cps_pkg::WIDE_W;
    localparam int MW  = cps_pkg::MAG_W;
    localparam int CW  = cps_pkg::COORD_W;
    localparam int PFW = MW + FW;
    localparam logic [PFW:0] HALF = (PFW + 1)'(1) << (FW - 1);

    typedef struct packed {
        cps_pkg::cps_vec_t   q;
        logic                wp;
        logic                wn;
        cps_pkg::cps_region_t region;
        logic [WW-1:0]       rem;
        logic [WW-1:0]       dd;
        logic [FW-1:0]       f;
    } proj_div_t;

    typedef struct packed {
        cps_pkg::cps_vec_t    q;
        logic                 wp;
        logic                 wn;
        cps_pkg::cps_region_t region;
    } proj_tag_t;

    logic      dv_valid_reg [0:FW];
    proj_div_t dv_reg       [0:FW];
    proj_div_t dv0_next;

    logic                mp_valid_reg;
    proj_tag_t           mp_tag_reg, mp_tag_next;
    logic [2:0][PFW-1:0] mp_reg, mp_next;

    logic             pt_valid_reg;
    cps_pkg::cps_pt_t pt_reg, pt_next;

    assign item_ready = adv;
    assign pt_valid   = pt_valid_reg;
    assign pt         = pt_reg;

    always_comb
    begin
        dv0_next.q      = item.q;
        dv0_next.wp     = item.wp;
        dv0_next.wn     = item.wn;
        dv0_next.region = item.region;
        dv0_next.rem    = item.rem;
        dv0_next.dd     = item.dd;
        dv0_next.f      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv0_next;
    end

    for (genvar j = 1; j <= FW; j++)
    begin : g_div
        proj_div_t   dv_next;
        logic [WW:0] rem2;
        logic        ge;

        always_comb
        begin
            rem2         = {dv_reg[j-1].rem, 1'b0};
            ge           = rem2 >= {1'b0, dv_reg[j-1].dd};
            dv_next      = dv_reg[j-1];
            dv_next.rem  = ge ? WW'(rem2 - {1'b0, dv_reg[j-1].dd}) : rem2[WW-1:0];
            dv_next.f    = {dv_reg[j-1].f[FW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (adv)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[j] <= dv_next;
        end
    end

    // offset along each axis before rounding
    always_comb
    begin
        mp_tag_next.q      = dv_reg[FW].q;
        mp_tag_next.wp     = dv_reg[FW].wp;
        mp_tag_next.wn     = dv_reg[FW].wn;
        mp_tag_next.region = dv_reg[FW].region;
        for (int i = 0; i < 3; i++)
            mp_next[i] = cps_pkg::mag(cps_pkg::seg_delta(seg, 2'(i))) * dv_reg[FW].f;
    end

    always_comb
    begin
        logic [PFW:0]  rnd;
        logic [MW-1:0] off;
        logic [MW-1:0] d;
        logic [CW+1:0] s_ext;
        pt_next.q       = mp_tag_reg.q;
        pt_next.wp      = mp_tag_reg.wp;
        pt_next.wn      = mp_tag_reg.wn;
        pt_next.on_edge = mp_tag_reg.region == cps_pkg::REG_EDGE;
        for (int i = 0; i < 3; i++)
        begin
            rnd   = {1'b0, mp_reg[i]} + HALF;
            off   = rnd[FW +: MW];
            d     = cps_pkg::seg_delta(seg, 2'(i));
            s_ext = {{2{seg.s[i][CW-1]}}, seg.s[i]};
            if (i >= DIMS)
                pt_next.c[i] = '0;
            else
            begin
                case (mp_tag_reg.region)
                    cps_pkg::REG_START: pt_next.c[i] = seg.s[i];
                    cps_pkg::REG_END:   pt_next.c[i] = seg.e[i];
                    cps_pkg::REG_EDGE:
                    begin
                        if (d[MW-1])
                            pt_next.c[i] = CW'(s_ext - {1'b0, off});
                        else
                            pt_next.c[i] = CW'(s_ext + {1'b0, off});
                    end
                    default:            pt_next.c[i] = seg.s[i];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_valid_reg <= 1'b0;
            pt_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mp_valid_reg <= dv_valid_reg[FW];
            pt_valid_reg <= mp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_tag_reg <= mp_tag_next;
            mp_reg     <= mp_next;
            pt_reg     <= pt_next;
        end
    end

endmodule

// File: src/cps_norm.sv
// ----------------------------------------------------------------------------
// cps_norm
// unit vector from the closest point to the query: range reduction,
// pipelined integer square root and per-axis restoring division
// ----------------------------------------------------------------------------
module cps_norm #(
    parameter int DIMS = cps_pkg::DIMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pt_valid,
    input  cps_pkg::cps_pt_t              pt,
    input  logic                          out_ready,
    output logic                          adv,
    output logic                          out_valid,
    output cps_pkg::cps_vec_t             out_point,
    output logic [2:0][cps_pkg::NRM_W-1:0] out_normal,
    output logic                          out_edge
);

    localparam int MW  = cps_pkg::MAG_W;
    localparam int CW  = cps_pkg::COORD_W;
    localparam int BW  = cps_pkg::B_W;
    localparam int SW  = cps_pkg::SH_W;
    localparam int QW  = cps_pkg::SQ_W;
    localparam int M2W = cps_pkg::M2_W;
    localparam int XW  = cps_pkg::ISQ_W;
    localparam int NS  = cps_pkg::SQ_STEPS;
    localparam int RW  = cps_pkg::R_W;
    localparam int UW  = cps_pkg::NUM_W;
    localparam int VW  = cps_pkg::QUO_W;
    localparam int NW  = cps_pkg::NRM_W;
    localparam int XTRA = MW - BW;

    typedef struct packed {
        cps_pkg::cps_vec_t point;
        logic              wn;
        logic              on_edge;
        logic [2:0]        neg;
    } norm_tag_t;

    typedef struct packed {
        norm_tag_t          tag;
        logic [2:0][BW-1:0] b;
        logic               zero;
        logic [XW-1:0]      x;
        logic [XW-1:0]      res;
    } norm_sq_t;

    typedef struct packed {
        norm_tag_t          tag;
        logic               zero;
        logic [RW-1:0]      r;
        logic [2:0][UW-1:0] num;
        logic [2:0][VW-1:0] quo;
    } norm_qd_t;

    logic               a_valid_reg, b_valid_reg, s_valid_reg;
    norm_tag_t          a_tag_reg, a_tag_next, b_tag_reg, s_tag_reg;
    logic [2:0][MW-1:0] a_reg, a_next;
    logic [2:0][BW-1:0] b_reg, b_next, bs_reg;
    logic [2:0][QW-1:0] sq_reg, sq_next;

    logic     sq_valid_reg [0:NS];
    norm_sq_t sqs_reg      [0:NS];
    norm_sq_t sq0_next;

    logic     qd_valid_reg [0:VW];
    norm_qd_t qd_reg       [0:VW];
    norm_qd_t qd0_next;

    logic                out_valid_reg, out_edge_reg, out_edge_next;
    cps_pkg::cps_vec_t   out_point_reg, out_point_next;
    logic [2:0][NW-1:0]  out_normal_reg, out_normal_next;

    assign adv        = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_point  = out_point_reg;
    assign out_normal = out_normal_reg;
    assign out_edge   = out_edge_reg;

    // offset from the closest point and the point word to return
    always_comb
    begin
        logic [MW-1:0] w;
        logic          use_pt;
        use_pt             = pt.wp || (pt.on_edge && pt.wn);
        a_tag_next.point   = use_pt ? pt.c : pt.q;
        a_tag_next.wn      = pt.wn;
        a_tag_next.on_edge = pt.on_edge;
        for (int i = 0; i < 3; i++)
        begin
            w = {pt.q[i][CW-1], pt.q[i]} - {pt.c[i][CW-1], pt.c[i]};
            if (i < DIMS)
            begin
                a_next[i]         = cps_pkg::mag(w);
                a_tag_next.neg[i] = w[MW-1];
            end
            else
            begin
                a_next[i]         = '0;
                a_tag_next.neg[i] = 1'b0;
            end
        end
    end

    // common right shift that brings every magnitude below 2^22
    always_comb
    begin
        logic [MW-1:0] any;
        logic [SW-1:0] sh;
        any = a_reg[0] | a_reg[1] | a_reg[2];
        sh  = '0;
        for (int k = 0; k < XTRA; k++)
            if (any[BW + k])
                sh = SW'(k + 1);
        for (int i = 0; i < 3; i++)
            b_next[i] = BW'(a_reg[i] >> sh);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = b_reg[i] * b_reg[i];
    end

    always_comb
    begin
        logic [M2W-1:0] m2;
        m2            = M2W'(sq_reg[0]) + M2W'(sq_reg[1]) + M2W'(sq_reg[2]);
        sq0_next.tag  = s_tag_reg;
        sq0_next.b    = bs_reg;
        sq0_next.zero = m2 == '0;
        sq0_next.x    = XW'({m2, 16'h0000});
        sq0_next.res  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            s_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= pt_valid;
            b_valid_reg     <= a_valid_reg;
            s_valid_reg     <= b_valid_reg;
            sq_valid_reg[0] <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tag_reg  <= a_tag_next;
            a_reg      <= a_next;
            b_tag_reg  <= a_tag_reg;
            b_reg      <= b_next;
            s_tag_reg  <= b_tag_reg;
            bs_reg     <= b_reg;
            sq_reg     <= sq_next;
            sqs_reg[0] <= sq0_next;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (NS - 1 - j));
        norm_sq_t      sq_next_s;
        logic [XW-1:0] trial;
        logic          ge;

        always_comb
        begin
            trial     = sqs_reg[j].res + BIT;
            ge        = sqs_reg[j].x >= trial;
            sq_next_s = sqs_reg[j];
            if (ge)
            begin
                sq_next_s.x   = sqs_reg[j].x - trial;
                sq_next_s.res = (sqs_reg[j].res >> 1) + BIT;
            end
            else
                sq_next_s.res = sqs_reg[j].res >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[j+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[j+1] <= sq_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                sqs_reg[j+1] <= sq_next_s;
        end
    end

    // rounded dividends b * 2^22 + r / 2
    always_comb
    begin
        logic [RW-1:0] r;
        r             = sqs_reg[NS].res[RW-1:0];
        qd0_next.tag  = sqs_reg[NS].tag;
        qd0_next.zero = sqs_reg[NS].zero;
        qd0_next.r    = r;
        for (int i = 0; i < 3; i++)
        begin
            qd0_next.num[i] = UW'({sqs_reg[NS].b[i], 22'h000000}) + UW'(r >> 1);
            qd0_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qd_valid_reg[0] <= 1'b0;
        else if (adv)
            qd_valid_reg[0] <= sq_valid_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            qd_reg[0] <= qd0_next;
    end

    // three lanes of restoring division, one quotient bit per stage
    for (genvar k = 0; k < VW; k++)
    begin : g_quo
        localparam int SH = VW - 1 - k;
        norm_qd_t      qd_next;
        logic [UW-1:0] den;

        always_comb
        begin
            den     = UW'(qd_reg[k].r) << SH;
            qd_next = qd_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (qd_reg[k].num[i] >= den)
                begin
                    qd_next.num[i] = qd_reg[k].num[i] - den;
                    qd_next.quo[i] = {qd_reg[k].quo[i][VW-2:0], 1'b1};
                end
                else
                    qd_next.quo[i] = {qd_reg[k].quo[i][VW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                qd_valid_reg[k+1] <= 1'b0;
            else if (adv)
                qd_valid_reg[k+1] <= qd_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                qd_reg[k+1] <= qd_next;
        end
    end

    always_comb
    begin
        logic [NW-1:0] v;
        out_point_next = qd_reg[VW].tag.point;
        out_edge_next  = qd_reg[VW].tag.on_edge;
        for (int i = 0; i < 3; i++)
        begin
            v = NW'(qd_reg[VW].quo[i]);
            if (v > NW'(cps_pkg::NRM_ONE))
                v = NW'(cps_pkg::NRM_ONE);
            if (!qd_reg[VW].tag.wn || qd_reg[VW].zero)
                out_normal_next[i] = '0;
            else if (qd_reg[VW].tag.neg[i])
                out_normal_next[i] = ~v + 1'b1;
            else
                out_normal_next[i] = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= qd_valid_reg[VW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_point_reg  <= out_point_next;
            out_normal_reg <= out_normal_next;
            out_edge_reg   <= out_edge_next;
        end
    end

endmodule
